@@ design/rgtd_pkg.sv @@
package rgtd_pkg;

    localparam int STATION_LEN = 8;
    localparam int TEXT_LEN    = 64;
    localparam int TEXT_LANES  = 4;
    localparam int TEXT_ROWS   = TEXT_LEN / TEXT_LANES;

    localparam int CHAR_W      = 7;
    localparam int IDX_W       = 6;
    localparam int STATION_W   = $clog2(STATION_LEN);
    localparam int ROW_W       = $clog2(TEXT_ROWS);
    localparam int LANE_W      = $clog2(TEXT_LANES);

    localparam logic [3:0] GTYPE_STATION = 4'h0;
    localparam logic [3:0] GTYPE_TEXT    = 4'h2;

    localparam logic [7:0] CHAR_CR       = 8'h0D;
    localparam logic [7:0] CHAR_LOW      = 8'h10;
    localparam logic [7:0] CHAR_HIGH     = 8'h7F;

    typedef enum logic [1:0] {
        ACT_GROUP        = 2'd0,
        ACT_READ_STATION = 2'd1,
        ACT_READ_TEXT    = 2'd2,
        ACT_CLEAR_TEXT   = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        SRC_NONE,
        SRC_STATION,
        SRC_TEXT
    } read_src_t;

    typedef struct packed {
        logic             wr;
        logic [1:0]       pair;
        logic [15:0]      chars;
        logic [IDX_W-1:0] rd_index;
    } station_cmd_t;

    typedef struct packed {
        logic             wr;
        logic             clr;
        logic [ROW_W-1:0] row;
        logic [31:0]      chars;
        logic [IDX_W-1:0] rd_index;
    } text_cmd_t;

    function automatic logic byte_ok(input logic [7:0] v);
        return ((v >= CHAR_LOW) && (v <= CHAR_HIGH)) || (v == CHAR_CR);
    endfunction

endpackage

@@ design/rgtd_station_store.sv @@
module rgtd_station_store (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            en,
    input  rgtd_pkg::station_cmd_t          cmd,
    output logic [rgtd_pkg::CHAR_W-1:0]     rd_char
);
    import rgtd_pkg::*;

    logic [CHAR_W-1:0]    chars_reg [STATION_LEN];
    logic [CHAR_W-1:0]    rd_char_reg;
    logic [STATION_W-1:0] pos_hi;
    logic [STATION_W-1:0] pos_lo;
    logic                 in_range;

    assign pos_hi   = {cmd.pair, 1'b0};
    assign pos_lo   = {cmd.pair, 1'b1};
    assign in_range = (cmd.rd_index[IDX_W-1:STATION_W] == '0);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < STATION_LEN; i++) begin
                chars_reg[i] <= '0;
            end
        end else if (en && cmd.wr) begin
            if (byte_ok(cmd.chars[15:8])) begin
                chars_reg[pos_hi] <= cmd.chars[14:8];
            end
            if (byte_ok(cmd.chars[7:0])) begin
                chars_reg[pos_lo] <= cmd.chars[6:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            rd_char_reg <= in_range ? chars_reg[cmd.rd_index[STATION_W-1:0]] : '0;
        end
    end

    assign rd_char = rd_char_reg;

endmodule

@@ design/rgtd_text_store.sv @@
module rgtd_text_store (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            en,
    input  rgtd_pkg::text_cmd_t             cmd,
    output logic [rgtd_pkg::CHAR_W-1:0]     rd_char
);
    import rgtd_pkg::*;

    logic [TEXT_LEN-1:0]   valid_reg;
    logic [TEXT_LEN-1:0]   valid_next;
    logic [TEXT_LANES-1:0] lane_we;
    logic [CHAR_W-1:0]     rd_word_reg [TEXT_LANES];
    logic [LANE_W-1:0]     rd_lane_reg;
    logic                  rd_valid_reg;
    logic [ROW_W-1:0]      rd_row;

    assign rd_row = cmd.rd_index[IDX_W-1:LANE_W];

    always_comb begin
        for (int k = 0; k < TEXT_LANES; k++) begin
            lane_we[k] = en && cmd.wr && byte_ok(cmd.chars[31-8*k -: 8]);
        end
    end

    generate
        for (genvar k = 0; k < TEXT_LANES; k++) begin : g_lane
            logic [CHAR_W-1:0] mem [TEXT_ROWS];

            always_ff @(posedge aclk) begin
                if (lane_we[k]) begin
                    mem[cmd.row] <= cmd.chars[30-8*k -: CHAR_W];
                end
            end

            always_ff @(posedge aclk) begin
                if (en) begin
                    rd_word_reg[k] <= mem[rd_row];
                end
            end
        end
    endgenerate

    always_comb begin
        valid_next = valid_reg;
        if (en && cmd.clr) begin
            valid_next = '0;
        end else begin
            for (int k = 0; k < TEXT_LANES; k++) begin
                if (lane_we[k]) begin
                    valid_next[{cmd.row, LANE_W'(k)}] = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            rd_lane_reg  <= cmd.rd_index[LANE_W-1:0];
            rd_valid_reg <= valid_reg[cmd.rd_index];
        end
    end

    assign rd_char = rd_valid_reg ? rd_word_reg[rd_lane_reg] : '0;

endmodule

@@ design/rds_group_text_decoder.sv @@
// channel  ports        fields from bit 0 up
// s_       tdata[55:0]  block_b[15:0] block_c[31:16] block_d[47:32] char_index[53:48]
// s_       tuser[2:0]   action[1:0] group_ready[2]
// m_       tdata[15:0]  status[0] text_segment[6:1] read_char[13:7]
//
// one item per cycle while m_tready holds; a taken item reaches the output through
// the input register, then the result register with the registered store reads
// reset clears both stores at once through flip-flops and per-character valid bits
// a stalled result holds in the result register while one more item waits in
// the input register
module rds_group_text_decoder (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [55:0] s_tdata,   // block_b, block_c, block_d, char_index
    input  logic [2:0]  s_tuser,   // action, group_ready
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata    // status, text_segment, read_char
);
    import rgtd_pkg::*;

    logic             in_valid_reg;
    logic             in_valid_next;
    action_t          in_action_reg;
    logic             in_ready_reg;
    logic [15:0]      in_b_reg;
    logic [15:0]      in_c_reg;
    logic [15:0]      in_d_reg;
    logic [IDX_W-1:0] in_idx_reg;

    logic             out_valid_reg;
    logic             out_valid_next;
    logic             status_reg;
    logic             status_next;
    read_src_t        src_reg;
    read_src_t        src_next;
    logic [IDX_W-1:0] segment_reg;
    logic [IDX_W-1:0] segment_next;

    logic             advance;
    logic             step;
    logic             s_accept;
    logic             group_in;
    logic             is_station;
    logic             is_text;

    station_cmd_t      st_cmd;
    text_cmd_t         tx_cmd;
    logic [CHAR_W-1:0] st_char;
    logic [CHAR_W-1:0] tx_char;
    logic [CHAR_W-1:0] read_char;

    assign advance  = !out_valid_reg || m_tready;
    assign step     = advance && in_valid_reg;
    assign s_tready = !in_valid_reg || advance;
    assign s_accept = s_tvalid && s_tready;

    assign group_in   = (in_action_reg == ACT_GROUP) && in_ready_reg;
    assign is_station = group_in && (in_b_reg[15:12] == GTYPE_STATION);
    assign is_text    = group_in && (in_b_reg[15:12] == GTYPE_TEXT);

    always_comb begin
        st_cmd.wr       = is_station;
        st_cmd.pair     = in_b_reg[1:0];
        st_cmd.chars    = in_d_reg;
        st_cmd.rd_index = in_idx_reg;

        tx_cmd.wr       = is_text;
        tx_cmd.clr      = (in_action_reg == ACT_CLEAR_TEXT);
        tx_cmd.row      = in_b_reg[ROW_W-1:0];
        tx_cmd.chars    = {in_c_reg, in_d_reg};
        tx_cmd.rd_index = in_idx_reg;
    end

    rgtd_station_store u_station (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (step),
        .cmd     (st_cmd),
        .rd_char (st_char)
    );

    rgtd_text_store u_text (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (step),
        .cmd     (tx_cmd),
        .rd_char (tx_char)
    );

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_accept) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        status_next    = status_reg;
        src_next       = src_reg;
        segment_next   = segment_reg;
        if (advance) begin
            out_valid_next = in_valid_reg;
        end
        if (step) begin
            status_next = is_station || is_text;
            case (in_action_reg)
                ACT_READ_STATION: src_next = SRC_STATION;
                ACT_READ_TEXT:    src_next = SRC_TEXT;
                default:          src_next = SRC_NONE;
            endcase
            if (is_text) begin
                segment_next = {in_b_reg[ROW_W-1:0], {LANE_W{1'b0}}};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            segment_reg   <= '0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            segment_reg   <= segment_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            in_action_reg <= action_t'(s_tuser[1:0]);
            in_ready_reg  <= s_tuser[2];
            in_b_reg      <= s_tdata[15:0];
            in_c_reg      <= s_tdata[31:16];
            in_d_reg      <= s_tdata[47:32];
            in_idx_reg    <= s_tdata[53:48];
        end
        status_reg <= status_next;
        src_reg    <= src_next;
    end

    always_comb begin
        case (src_reg)
            SRC_STATION: read_char = st_char;
            SRC_TEXT:    read_char = tx_char;
            default:     read_char = '0;
        endcase
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'b00, read_char, segment_reg, status_reg};

endmodule

@@ bench/rds_group_text_decoder_tb.sv @@
module rds_group_text_decoder_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import rgtd_pkg::*;

    typedef struct {
        action_t     action;
        logic        group_ready;
        logic [15:0] block_b;
        logic [15:0] block_c;
        logic [15:0] block_d;
        logic [5:0]  char_index;
    } rds_item_t;

    typedef struct {
        logic       status;
        logic [5:0] text_segment;
        logic [6:0] read_char;
    } rds_result_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [55:0] s_tdata  = '0;
    logic [2:0]  s_tuser  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;

    rds_group_text_decoder dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // model state
    logic [6:0] station_mem [STATION_LEN];
    logic [6:0] text_mem [TEXT_LEN];
    logic [5:0] seg_now;

    rds_item_t   item_q [$];
    rds_result_t expected_q [$];

    int error_count    = 0;
    int total_items    = 0;
    int taken_cnt      = 0;
    int results_seen   = 0;
    int groups_stored  = 0;
    int reads_done     = 0;
    int clears_done    = 0;
    logic took_last    = 1'b0;

    int burst_left = 1;
    int gap_left   = 0;
    int sink_mode  = 0;
    int sink_left  = 0;

    task automatic report_mismatch(input string msg);
        $display("mismatch at %0t ns: %s", $time, msg);
        error_count++;
    endtask

    function automatic logic char_storable(input logic [7:0] v);
        return (v >= CHAR_LOW && v <= CHAR_HIGH) || v == CHAR_CR;
    endfunction

    function automatic void put_text(input int pos, input logic [7:0] v);
        if (pos < TEXT_LEN && char_storable(v))
            text_mem[pos] = v[6:0];
    endfunction

    function automatic void put_station(input int pos, input logic [7:0] v);
        if (pos < STATION_LEN && char_storable(v))
            station_mem[pos] = v[6:0];
    endfunction

    function automatic rds_result_t decode_group(input rds_item_t it);
        rds_result_t r;
        logic [3:0]  gtype;
        int          base;
        r.status    = 1'b0;
        r.read_char = '0;
        gtype       = it.block_b[15:12];
        case (it.action)
            ACT_GROUP: begin
                if (it.group_ready && gtype == GTYPE_STATION) begin
                    base = int'(it.block_b[1:0]) * 2;
                    put_station(base, it.block_d[15:8]);
                    put_station(base + 1, it.block_d[7:0]);
                    r.status = 1'b1;
                end else if (it.group_ready && gtype == GTYPE_TEXT) begin
                    base = int'(it.block_b[3:0]) * 4;
                    seg_now = base[5:0];
                    put_text(base, it.block_c[15:8]);
                    put_text(base + 1, it.block_c[7:0]);
                    put_text(base + 2, it.block_d[15:8]);
                    put_text(base + 3, it.block_d[7:0]);
                    r.status = 1'b1;
                end
                if (r.status) groups_stored++;
            end
            ACT_READ_STATION: begin
                if (it.char_index < STATION_LEN)
                    r.read_char = station_mem[it.char_index[STATION_W-1:0]];
                reads_done++;
            end
            ACT_READ_TEXT: begin
                r.read_char = text_mem[it.char_index];
                reads_done++;
            end
            default: begin
                for (int i = 0; i < TEXT_LEN; i++)
                    text_mem[i] = '0;
                clears_done++;
            end
        endcase
        r.text_segment = seg_now;
        return r;
    endfunction

    function automatic rds_item_t make_group(input logic ready, input logic [15:0] b,
                                             input logic [15:0] c, input logic [15:0] d);
        rds_item_t it;
        it.action      = ACT_GROUP;
        it.group_ready = ready;
        it.block_b     = b;
        it.block_c     = c;
        it.block_d     = d;
        it.char_index  = 6'($urandom);
        return it;
    endfunction

    function automatic rds_item_t make_op(input action_t act, input logic [5:0] idx);
        rds_item_t it;
        it.action      = act;
        it.group_ready = 1'($urandom);
        it.block_b     = 16'($urandom);
        it.block_c     = 16'($urandom);
        it.block_d     = 16'($urandom);
        it.char_index  = idx;
        return it;
    endfunction

    // mostly printable, some boundary values, some raw bytes
    function automatic logic [7:0] rand_char();
        int r;
        logic [7:0] edge_chars [6];
        edge_chars = '{8'h0D, 8'h10, 8'h7F, 8'h0F, 8'h80, 8'hFF};
        r = $urandom_range(0, 9);
        if (r < 8) return 8'($urandom_range(8'h20, 8'h7E));
        if (r == 8) return edge_chars[$urandom_range(0, 5)];
        return 8'($urandom);
    endfunction

    function automatic rds_item_t rand_item();
        int         r;
        logic [3:0] gtype;
        r = $urandom_range(0, 99);
        if (r < 45) begin
            gtype = ($urandom_range(0, 1) == 0) ? GTYPE_STATION : GTYPE_TEXT;
            return make_group(1'b1, {gtype, 12'($urandom)},
                              {rand_char(), rand_char()}, {rand_char(), rand_char()});
        end
        if (r < 50)
            return make_group(1'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
        if (r < 72)
            return make_op(ACT_READ_TEXT, 6'($urandom));
        if (r < 97) begin
            if ($urandom_range(0, 4) != 0)
                return make_op(ACT_READ_STATION, 6'($urandom_range(0, STATION_LEN - 1)));
            return make_op(ACT_READ_STATION, 6'($urandom));
        end
        return make_op(ACT_CLEAR_TEXT, 6'($urandom));
    endfunction

    // sender: bursts with random gaps
    always @(negedge aclk) begin : drive_proc
        rds_item_t nxt;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (s_tvalid && !took_last) begin
            // hold until taken
        end else if (gap_left > 0) begin
            gap_left <= gap_left - 1;
            s_tvalid <= 1'b0;
        end else if (item_q.size() > 0) begin
            nxt = item_q.pop_front();
            s_tdata  <= {2'b00, nxt.char_index, nxt.block_d, nxt.block_c, nxt.block_b};
            s_tuser  <= {nxt.group_ready, nxt.action};
            s_tvalid <= 1'b1;
            if (burst_left <= 1) begin
                burst_left <= $urandom_range(1, 40);
                gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
            end else begin
                burst_left <= burst_left - 1;
            end
        end else begin
            s_tvalid <= 1'b0;
        end
    end

    // receiver: randomly chosen stall modes
    always @(negedge aclk) begin : sink_proc
        if (sink_left == 0) begin
            sink_mode <= $urandom_range(0, 4);
            sink_left <= $urandom_range(20, 80);
        end else begin
            sink_left <= sink_left - 1;
        end
        case (sink_mode)
            0: m_tready <= 1'b1;
            1: m_tready <= ($urandom_range(0, 3) != 0);
            2: m_tready <= ~m_tready;
            3: m_tready <= ($urandom_range(0, 3) == 0);
            default: m_tready <= 1'b0;
        endcase
    end

    always @(posedge aclk) begin : check_proc
        rds_item_t   it;
        rds_result_t got;
        rds_result_t want;
        took_last <= aresetn && s_tvalid && s_tready;
        if (aresetn && m_tvalid && m_tready) begin
            got.status       = m_tdata[0];
            got.text_segment = m_tdata[6:1];
            got.read_char    = m_tdata[13:7];
            results_seen++;
            if (expected_q.size() == 0) begin
                report_mismatch($sformatf("result 0x%04h with nothing expected", m_tdata));
            end else begin
                want = expected_q.pop_front();
                if (got.status !== want.status)
                    report_mismatch($sformatf("result %0d status %0b, expected %0b",
                                              results_seen, got.status, want.status));
                if (got.text_segment !== want.text_segment)
                    report_mismatch($sformatf("result %0d text_segment %0d, expected %0d",
                                              results_seen, got.text_segment,
                                              want.text_segment));
                if (got.read_char !== want.read_char)
                    report_mismatch($sformatf("result %0d read_char 0x%02h, expected 0x%02h",
                                              results_seen, got.read_char, want.read_char));
            end
        end
        if (aresetn && s_tvalid && s_tready) begin
            it.action      = action_t'(s_tuser[1:0]);
            it.group_ready = s_tuser[2];
            it.block_b     = s_tdata[15:0];
            it.block_c     = s_tdata[31:16];
            it.block_d     = s_tdata[47:32];
            it.char_index  = s_tdata[53:48];
            expected_q.push_back(decode_group(it));
            taken_cnt++;
        end
    end

    initial begin
        for (int i = 0; i < STATION_LEN; i++) station_mem[i] = '0;
        for (int i = 0; i < TEXT_LEN; i++) text_mem[i] = '0;
        seg_now = '0;

        // empty slots and out of range station index
        item_q.push_back(make_op(ACT_READ_STATION, 6'd0));
        item_q.push_back(make_op(ACT_READ_TEXT, 6'd63));
        item_q.push_back(make_op(ACT_READ_STATION, 6'd63));
        // group not ready, other group type
        item_q.push_back(make_group(1'b0, 16'h0000, 16'h4142, 16'h4142));
        item_q.push_back(make_group(1'b1, 16'h5003, 16'h4142, 16'h4344));
        item_q.push_back(make_group(1'b1, 16'hF0F0, 16'hFFFF, 16'hFFFF));
        // station name writes, byte filter edges
        item_q.push_back(make_group(1'b1, 16'h0000, 16'h0000, 16'h4142));
        item_q.push_back(make_group(1'b1, 16'h0003, 16'hFFFF, 16'h0D10));
        item_q.push_back(make_group(1'b1, 16'h0FFD, 16'h0000, 16'h0F80));
        item_q.push_back(make_group(1'b1, 16'h0002, 16'h0000, 16'h7F7F));
        item_q.push_back(make_group(1'b1, 16'h0002, 16'h0000, 16'hFF20));
        // radiotext writes, lowest and highest segment
        item_q.push_back(make_group(1'b1, 16'h2000, 16'h4849, 16'h4A4B));
        item_q.push_back(make_group(1'b1, 16'h2FFF, 16'hFFFF, 16'h0D10));
        item_q.push_back(make_group(1'b0, 16'h2005, 16'h5051, 16'h5253));
        item_q.push_back(make_op(ACT_READ_STATION, 6'd1));
        item_q.push_back(make_op(ACT_READ_STATION, 6'd4));
        item_q.push_back(make_op(ACT_READ_STATION, 6'd5));
        item_q.push_back(make_op(ACT_READ_STATION, 6'd7));
        item_q.push_back(make_op(ACT_READ_TEXT, 6'd0));
        item_q.push_back(make_op(ACT_READ_TEXT, 6'd61));
        item_q.push_back(make_op(ACT_READ_TEXT, 6'd62));
        // clear keeps the segment
        item_q.push_back(make_op(ACT_CLEAR_TEXT, 6'd0));
        item_q.push_back(make_op(ACT_READ_TEXT, 6'd0));
        item_q.push_back(make_op(ACT_READ_TEXT, 6'd62));
        for (int i = 0; i < 400; i++)
            item_q.push_back(rand_item());
        total_items = item_q.size();

        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        while (taken_cnt < total_items) @(posedge aclk);
        while (expected_q.size() != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);
        if (expected_q.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", expected_q.size()));

        $display("ran %0d items: %0d groups stored, %0d reads, %0d radiotext clears",
                 taken_cnt, groups_stored, reads_done, clears_done);
        $display("checked %0d results under random source gaps and sink stalls",
                 results_seen);
        if (error_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("%0d mismatches", error_count);
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    initial begin
        #3ms;
        $display("timeout with %0d of %0d items taken", taken_cnt, total_items);
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
